[rtl/core/sbts_pkg.sv]
package sbts_pkg;

   localparam int DIGIT_COUNT = 3;
   localparam int SEG_BITS    = 7;
   localparam int FRAME_BITS  = SEG_BITS * DIGIT_COUNT;
   localparam int COUNT_W     = $clog2(FRAME_BITS + 1);
   localparam int TEMP_W      = 10;
   localparam int DIGIT_W     = 4;
   localparam int GAP_W       = 16;
   localparam int REPEAT_W    = 8;
   localparam int CSR_DATA_W  = 16;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // register indexes on the csr port
   localparam logic CSR_GAP_LENGTH     = 1'b0;
   localparam logic CSR_STABLE_REPEATS = 1'b1;

   localparam logic [GAP_W-1:0]    GAP_LENGTH_RST     = GAP_W'(1000);
   localparam logic [REPEAT_W-1:0] STABLE_REPEATS_RST = REPEAT_W'(10);

   typedef struct packed {
      logic [GAP_W-1:0]    gap_length;
      logic [REPEAT_W-1:0] stable_repeats;
   } cfg_type;

   typedef struct packed {
      logic                  valid;
      logic [FRAME_BITS-1:0] bits;
   } frame_push_type;

   typedef struct packed {
      logic               hit;
      logic [DIGIT_W-1:0] digit;
   } seg_match_type;

   function automatic seg_match_type seg_decode(input logic [SEG_BITS-1:0] grp);
      seg_match_type m;
      m.hit = 1'b1;
      unique case (grp)
         7'h3F:   m.digit = 4'd0;
         7'h06:   m.digit = 4'd1;
         7'h5B:   m.digit = 4'd2;
         7'h4F:   m.digit = 4'd3;
         7'h66:   m.digit = 4'd4;
         7'h6D:   m.digit = 4'd5;
         7'h7D:   m.digit = 4'd6;
         7'h07:   m.digit = 4'd7;
         7'h7F:   m.digit = 4'd8;
         7'h6F:   m.digit = 4'd9;
         7'h10:   m.digit = 4'd0;   // lone segment on bit 4
         7'h16:   m.digit = 4'd1;
         7'h00:   m.digit = 4'd0;   // blank digit
         default: begin
            m.hit   = 1'b0;
            m.digit = 4'd0;
         end
      endcase
      return m;
   endfunction

endpackage

[rtl/core/sbts_front.sv]
module sbts_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic                    clock_level,
   input  logic                    data_level,
   input  sbts_pkg::cfg_type       cfg,
   output sbts_pkg::frame_push_type push
);
   import sbts_pkg::*;

   logic                  synced_ff, synced_in;
   logic                  prev_clock_ff, prev_clock_in;
   logic [GAP_W-1:0]      low_run_ff, low_run_in;
   logic [FRAME_BITS-1:0] bit_store_ff, bit_store_in;
   logic [COUNT_W-1:0]    bit_count_ff, bit_count_in;

   logic [GAP_W-1:0]      gap;
   logic                  gap_hit;
   logic [FRAME_BITS-1:0] store_cap;
   logic [COUNT_W-1:0]    count_cap;

   assign gap = (cfg.gap_length == '0) ? GAP_W'(1) : cfg.gap_length;

   always_comb begin
      store_cap = bit_store_ff;
      count_cap = bit_count_ff;
      if (prev_clock_ff && !clock_level && synced_ff &&
          bit_count_ff < COUNT_W'(FRAME_BITS)) begin
         store_cap = bit_store_ff | (FRAME_BITS'(data_level) << bit_count_ff);
         count_cap = bit_count_ff + COUNT_W'(1);
      end

      gap_hit    = 1'b0;
      low_run_in = low_run_ff;
      if (clock_level) begin
         low_run_in = '0;
      end else if (low_run_ff < gap) begin
         low_run_in = low_run_ff + GAP_W'(1);
         gap_hit    = (low_run_in == gap);
      end

      prev_clock_in = clock_level;
      synced_in     = synced_ff;
      bit_store_in  = store_cap;
      bit_count_in  = count_cap;
      push.valid    = 1'b0;
      push.bits     = store_cap;
      if (gap_hit) begin
         // a frame that is short goes nowhere; it cannot change the reading
         push.valid   = accept && synced_ff && (count_cap == COUNT_W'(FRAME_BITS));
         synced_in    = 1'b1;
         bit_store_in = '0;
         bit_count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         synced_ff     <= 1'b0;
         prev_clock_ff <= 1'b0;
         low_run_ff    <= '0;
         bit_store_ff  <= '0;
         bit_count_ff  <= '0;
      end else if (accept) begin
         synced_ff     <= synced_in;
         prev_clock_ff <= prev_clock_in;
         low_run_ff    <= low_run_in;
         bit_store_ff  <= bit_store_in;
         bit_count_ff  <= bit_count_in;
      end
   end

endmodule

[rtl/core/sbts_fifo.sv]
module sbts_fifo (
   input  logic                                 clock,
   input  logic                                 reset,
   input  sbts_pkg::frame_push_type             push,
   output logic                                 full,
   output logic                                 head_valid,
   output logic [sbts_pkg::FRAME_BITS-1:0]      head_bits,
   input  logic                                 pop
);
   import sbts_pkg::*;

   logic [FRAME_BITS-1:0] slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]     count_ff;
   logic                  do_pop;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_bits  = slot_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_ff @(posedge clock) begin
      if (push.valid) begin
         slot_ff[wr_ptr_ff] <= push.bits;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push.valid) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         case ({push.valid, do_pop})
            2'b10:   count_ff <= count_ff + QCNT_W'(1);
            2'b01:   count_ff <= count_ff - QCNT_W'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

[rtl/core/sbts_back.sv]
module sbts_back (
   input  logic                              clock,
   input  logic                              reset,
   input  sbts_pkg::cfg_type                 cfg,
   input  logic                              head_valid,
   input  logic [sbts_pkg::FRAME_BITS-1:0]   head_bits,
   output logic                              pop,
   output logic                              out_valid,
   output logic [sbts_pkg::TEMP_W-1:0]       out_value,
   input  logic                              out_ready
);
   import sbts_pkg::*;

   // decode stage
   logic              s1_valid_ff, s1_valid_in;
   logic              s1_ok_ff;
   logic [TEMP_W-1:0] s1_value_ff;
   logic              dec_ok;
   logic [TEMP_W-1:0] dec_value;

   // stability state
   logic              cand_valid_ff, cand_valid_in;
   logic [TEMP_W-1:0] cand_value_ff, cand_value_in;
   logic [REPEAT_W-1:0] repeat_ff, repeat_in;
   logic [TEMP_W-1:0] reported_ff, reported_in;
   logic              emit;

   logic              out_valid_ff;
   logic [TEMP_W-1:0] out_value_ff;

   logic              s2_fire, s1_load;

   // most significant digit sits in the lowest group
   always_comb begin
      seg_match_type m;
      dec_ok    = 1'b1;
      dec_value = '0;
      for (int n = 0; n < DIGIT_COUNT; n++) begin
         m         = seg_decode(head_bits[SEG_BITS*n +: SEG_BITS]);
         dec_ok    = dec_ok && m.hit;
         dec_value = TEMP_W'(dec_value * TEMP_W'(10) + TEMP_W'(m.digit));
      end
   end

   assign s2_fire     = s1_valid_ff && (!out_valid_ff || out_ready);
   assign s1_load     = !s1_valid_ff || s2_fire;
   assign pop         = head_valid && s1_load;
   assign s1_valid_in = s1_load ? head_valid : s1_valid_ff;

   always_comb begin
      cand_valid_in = cand_valid_ff;
      cand_value_in = cand_value_ff;
      repeat_in     = repeat_ff;
      reported_in   = reported_ff;
      emit          = 1'b0;
      if (s1_ok_ff) begin
         if (!cand_valid_ff || s1_value_ff == cand_value_ff) begin
            cand_valid_in = 1'b1;
            cand_value_in = s1_value_ff;
            if (repeat_ff < cfg.stable_repeats) begin
               repeat_in = repeat_ff + REPEAT_W'(1);
            end
            if (repeat_in >= cfg.stable_repeats && reported_ff != s1_value_ff) begin
               reported_in = s1_value_ff;
               emit        = 1'b1;
            end
         end else begin
            repeat_in     = '0;
            cand_value_in = s1_value_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_ok_ff    <= dec_ok && (dec_value != '0);
         s1_value_ff <= dec_value;
      end
      if (s2_fire && emit) begin
         out_value_ff <= s1_value_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         cand_valid_ff <= 1'b0;
         cand_value_ff <= '0;
         repeat_ff     <= '0;
         reported_ff   <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (s2_fire) begin
            cand_valid_ff <= cand_valid_in;
            cand_value_ff <= cand_value_in;
            repeat_ff     <= repeat_in;
            reported_ff   <= reported_in;
         end
         if (s2_fire && emit) begin
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign out_valid = out_valid_ff;
   assign out_value = out_value_ff;

endmodule

[rtl/core/segment_bus_temperature_sniffer.sv]
// Path: a reading leaves on rsp_ once the gap sample that closes its frame has passed
//   the queue write, decode register and output register, later if rsp_tready is held low.
// Throughput: one sample per cycle; req_tready drops only while the frame queue is full.
// Reset: synchronous, active high; clears sync, counters, queue and stability state,
//   and loads gap_length = 1000, stable_repeats = 10.
module segment_bus_temperature_sniffer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,  // [0] clock_level, [1] data_level
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [15:0]                       rsp_tdata,  // [9:0] stable_temperature
   input  logic                              csr_we,
   input  logic                              csr_index,
   input  logic [sbts_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import sbts_pkg::*;

   cfg_type               cfg_ff;
   frame_push_type        push;
   logic                  q_full, q_head_valid, q_pop;
   logic [FRAME_BITS-1:0] q_head_bits;
   logic [TEMP_W-1:0]     out_value;
   logic                  accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gap_length     <= GAP_LENGTH_RST;
         cfg_ff.stable_repeats <= STABLE_REPEATS_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_GAP_LENGTH:     cfg_ff.gap_length     <= csr_wdata[GAP_W-1:0];
            CSR_STABLE_REPEATS: cfg_ff.stable_repeats <= csr_wdata[REPEAT_W-1:0];
            default:            cfg_ff <= cfg_ff;
         endcase
      end
   end

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   sbts_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .clock_level (req_tdata[0]),
      .data_level  (req_tdata[1]),
      .cfg         (cfg_ff),
      .push        (push)
   );

   sbts_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (q_full),
      .head_valid (q_head_valid),
      .head_bits  (q_head_bits),
      .pop        (q_pop)
   );

   sbts_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (q_head_valid),
      .head_bits  (q_head_bits),
      .pop        (q_pop),
      .out_valid  (rsp_tvalid),
      .out_value  (out_value),
      .out_ready  (rsp_tready)
   );

   assign rsp_tdata = {(16 - TEMP_W)'(0), out_value};

endmodule

[rtl/core/sbts_checker.sv]
module sbts_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [7:0]  req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        csr_we,
   input logic        csr_index,
   input logic [15:0] csr_wdata
);

   // a waiting transaction holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp transaction changed while stalled");

   a_rsp_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[9:0] != 10'd0)
      else $error("zero reading reported");

   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[15:10] == 6'd0)
      else $error("rsp_tdata padding not zero");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result shown straight after reset");

   // a new report differs from the one just taken
   a_changed: assert property (@(posedge clock) disable iff (reset)
      $past(rsp_tvalid && rsp_tready) && rsp_tvalid && $past(!reset)
      |-> rsp_tdata != $past(rsp_tdata))
      else $error("same reading reported twice in a row");

endmodule

bind segment_bus_temperature_sniffer sbts_checker u_sbts_checker (.*);

[verif/segment_bus_temperature_sniffer_test.sv]
`timescale 1ns / 100ps

module segment_bus_temperature_sniffer_test;
   import sbts_pkg::*;

   typedef enum int {
      FAULT_SHORT,
      FAULT_UNMATCHED,
      FAULT_ZERO,
      FAULT_NOISE
   } fault_kind_type;

   // segment patterns and the digit each one shows
   localparam logic [SEG_BITS-1:0] SEG_PAT [0:12] = '{
      7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F,
      7'h10, 7'h16, 7'h00
   };
   localparam int SEG_VAL [0:12] = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 0, 1, 0};

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata = '0;   // [0] clock_level, [1] data_level
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [15:0]           rsp_tdata;        // [9:0] stable_temperature
   logic                  csr_we = 1'b0;
   logic                  csr_index = 1'b0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   segment_bus_temperature_sniffer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // sniffer state as predicted
   logic [GAP_W-1:0]      gap_setting;
   logic [REPEAT_W-1:0]   repeat_setting;
   bit                    line_synced;
   bit                    last_clock;
   int                    low_count;
   logic [FRAME_BITS-1:0] held_bits;
   int                    held_count;
   logic [TEMP_W-1:0]     cand_temp;
   bit                    cand_ok;
   int                    same_count;
   logic [TEMP_W-1:0]     last_reported;

   logic [TEMP_W-1:0]     expected_temps [$];
   int                    temps_predicted = 0;
   int                    samples_taken = 0;
   int                    mismatch_count = 0;
   bit                    sender_idles = 1'b0;
   bit                    receiver_stalls = 1'b0;
   int                    stall_left = 0;

   task automatic report_mismatch(input string msg);
      $display("%0t ERROR %s", $time, msg);
      mismatch_count++;
   endtask

   function automatic int group_digit(logic [SEG_BITS-1:0] grp);
      for (int i = 0; i < 13; i++)
         if (SEG_PAT[i] == grp) return SEG_VAL[i];
      return -1;
   endfunction

   function automatic int decode_held();
      int d;
      int reading;
      if (held_count < FRAME_BITS) return -1;
      reading = 0;
      for (int n = 0; n < DIGIT_COUNT; n++) begin
         d = group_digit(held_bits[n*SEG_BITS +: SEG_BITS]);
         if (d < 0) return -1;
         reading = reading * 10 + d;
      end
      return reading;
   endfunction

   function automatic void track_sample(bit clk, bit dat);
      int                gap_eff;
      bit                gap_hit;
      int                reading;
      logic [TEMP_W-1:0] v;
      gap_eff = (gap_setting == 0) ? 1 : int'(gap_setting);
      gap_hit = 1'b0;
      if (last_clock && !clk && line_synced && held_count < FRAME_BITS) begin
         held_bits[held_count] = dat;
         held_count++;
      end
      last_clock = clk;
      if (clk) begin
         low_count = 0;
      end else if (low_count < gap_eff) begin
         low_count++;
         if (low_count >= gap_eff) gap_hit = 1'b1;
      end
      if (!gap_hit) return;
      if (line_synced) begin
         reading = decode_held();
         if (reading >= 1) begin
            v = TEMP_W'(reading);
            if (!cand_ok) begin
               cand_ok = 1'b1;
               cand_temp = v;
            end
            if (v == cand_temp) begin
               if (same_count < repeat_setting) same_count++;
               if (same_count >= repeat_setting && last_reported != v) begin
                  last_reported = v;
                  expected_temps.push_back(v);
                  temps_predicted++;
               end
            end else begin
               // a changed reading only starts counting from its next repeat
               same_count = 0;
               cand_temp = v;
            end
         end
      end
      line_synced = 1'b1;
      held_bits = '0;
      held_count = 0;
   endfunction

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         track_sample(req_tdata[0], req_tdata[1]);
         samples_taken++;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_temps.size() == 0) begin
            report_mismatch($sformatf("reading %0d with none pending", rsp_tdata));
         end else begin
            if (rsp_tdata !== {{(16-TEMP_W){1'b0}}, expected_temps[0]})
               report_mismatch($sformatf("stable_temperature %0d, predicted %0d",
                                         rsp_tdata, expected_temps[0]));
            void'(expected_temps.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (receiver_stalls && $urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 4);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_sample(bit clk, bit dat);
      if (sender_idles && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {6'b0, dat, clk};
      do @(posedge clock); while (!req_tready);
   endtask

   // wait until every predicted reading has left, then let the pipeline empty
   task automatic settle();
      req_tvalid <= 1'b0;
      while (expected_temps.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [CSR_DATA_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      if (idx == CSR_GAP_LENGTH) gap_setting = data;
      else repeat_setting = data[REPEAT_W-1:0];
   endtask

   task automatic set_config(int gap, int repeats);
      settle();
      write_reg(CSR_GAP_LENGTH, 16'(gap));
      write_reg(CSR_STABLE_REPEATS, {8'($urandom_range(0, 255)), 8'(repeats)});
      csr_we <= 1'b0;
   endtask

   function automatic int pattern_for(int digit);
      if (digit == 0) begin
         case ($urandom_range(0, 2))
            0: return 0;
            1: return 10;
            default: return 12;
         endcase
      end
      if (digit == 1) return ($urandom_range(0, 1) == 0) ? 1 : 11;
      return digit;
   endfunction

   function automatic logic [FRAME_BITS-1:0] frame_for(int reading);
      logic [FRAME_BITS-1:0] bits;
      bits[6:0]   = SEG_PAT[pattern_for(reading / 100)];
      bits[13:7]  = SEG_PAT[pattern_for((reading / 10) % 10)];
      bits[20:14] = SEG_PAT[pattern_for(reading % 10)];
      return bits;
   endfunction

   task automatic send_frame(logic [FRAME_BITS-1:0] bits, int nbits);
      int gap_eff;
      int low_len;
      low_len = 0;
      gap_eff = (gap_setting == 0) ? 1 : int'(gap_setting);
      for (int k = 0; k < nbits; k++) begin
         repeat ($urandom_range(0, 9) == 0 ? 3 : $urandom_range(1, 2))
            send_sample(1'b1, 1'($urandom));
         if (gap_eff < 2) low_len = 1;
         else if (gap_eff <= 64 && $urandom_range(0, 15) == 0) low_len = gap_eff - 1;
         else low_len = $urandom_range(1, (gap_eff - 1 < 6) ? gap_eff - 1 : 6);
         send_sample(1'b0, (k < FRAME_BITS) ? bits[k] : 1'($urandom));
         repeat (low_len - 1) send_sample(1'b0, 1'($urandom));
      end
      // keep the clock low until the gap closes the frame
      repeat (gap_eff - low_len + $urandom_range(0, 2)) send_sample(1'b0, 1'($urandom));
   endtask

   task automatic send_gap();
      int gap_eff;
      gap_eff = (gap_setting == 0) ? 1 : int'(gap_setting);
      send_sample(1'b1, 1'($urandom));
      repeat (gap_eff) send_sample(1'b0, 1'($urandom));
   endtask

   task automatic send_noise(int n);
      repeat (n) send_sample(1'($urandom), 1'($urandom));
      send_gap();
   endtask

   task automatic send_reading(int reading);
      // now and then a frame runs on past its last digit
      if ($urandom_range(0, 7) == 0)
         send_frame(frame_for(reading), FRAME_BITS + $urandom_range(1, 9));
      else
         send_frame(frame_for(reading), FRAME_BITS);
   endtask

   task automatic send_fault(fault_kind_type kind);
      logic [FRAME_BITS-1:0] bits;
      logic [SEG_BITS-1:0]   grp;
      int                    n;
      case (kind)
         FAULT_SHORT: send_frame(frame_for($urandom_range(1, 999)),
                                 $urandom_range(1, FRAME_BITS - 1));
         FAULT_UNMATCHED: begin
            bits = frame_for($urandom_range(0, 999));
            do grp = SEG_BITS'($urandom); while (group_digit(grp) >= 0);
            n = $urandom_range(0, DIGIT_COUNT - 1);
            bits[n*SEG_BITS +: SEG_BITS] = grp;
            send_frame(bits, FRAME_BITS);
         end
         FAULT_ZERO: send_frame(frame_for(0), FRAME_BITS);
         default: send_noise($urandom_range(1, 40));
      endcase
   endtask

   task automatic run_reading(int reading, int count, bit with_faults);
      repeat (count) begin
         if (with_faults && $urandom_range(0, 5) == 0)
            send_fault(fault_kind_type'($urandom_range(0, 3)));
         send_reading(reading);
      end
   endtask

   // register values from reset; edges before the first gap are ignored
   task automatic test_default_settings();
      send_noise(30);
      run_reading(372, 11, 1'b0);
   endtask

   task automatic test_gap_extremes();
      set_config(0, 0);
      send_noise(20);
      run_reading(5, 2, 1'b0);
      set_config(1, 1);
      run_reading(48, 2, 1'b0);
      send_noise(10);
      set_config(16'hFFFF, 0);
      // the widest gap: a long low run still leaves the frame open
      repeat (40) send_sample(1'($urandom), 1'($urandom));
      send_sample(1'b1, 1'($urandom));
      repeat (1500) send_sample(1'b0, 1'($urandom));
      // the low run already lies past the new gap; only a high sample restarts it
      set_config(2, 0);
      run_reading(999, 2, 1'b0);
   endtask

   task automatic test_segment_table();
      logic [FRAME_BITS-1:0] bits;
      set_config(3, 0);
      for (int p = 0; p < 13; p++) begin
         bits = {SEG_PAT[(p + 2) % 13], SEG_PAT[(p + 1) % 13], SEG_PAT[p]};
         send_frame(bits, FRAME_BITS);
         send_frame(bits, FRAME_BITS);
      end
   endtask

   task automatic test_frame_faults();
      set_config(4, 1);
      run_reading(123, 2, 1'b0);
      send_reading(456);
      send_fault(FAULT_SHORT);
      send_fault(FAULT_UNMATCHED);
      send_fault(FAULT_ZERO);
      send_fault(FAULT_NOISE);
      send_reading(456);
      send_frame(frame_for(789), FRAME_BITS + 9);
      send_frame(frame_for(789), FRAME_BITS + 4);
      run_reading(10, 1, 1'b0);
      run_reading(456, 2, 1'b0);
   endtask

   task automatic test_long_stability();
      set_config(5, 255);
      run_reading(640, 259, 1'b1);
   endtask

   task automatic test_random_traffic();
      int first_sample;
      int first_temp;
      int phase;
      int reading;
      first_sample = samples_taken;
      first_temp = temps_predicted;
      phase = 0;
      while ((samples_taken - first_sample < 1400 || temps_predicted - first_temp < 48)
             && phase < 400) begin
         // each new setting waits for all pending readings to drain first
         if ($urandom_range(0, 9) == 0)
            set_config($urandom_range(0, 1), $urandom_range(0, 3));
         else
            set_config($urandom_range(2, 10),
                       ($urandom_range(0, 5) == 0) ? $urandom_range(4, 8)
                                                   : $urandom_range(0, 3));
         sender_idles = ($urandom_range(0, 3) != 0);
         receiver_stalls = ($urandom_range(0, 3) != 0);
         repeat (8) begin
            if ($urandom_range(0, 9) == 0) begin
               send_fault(fault_kind_type'($urandom_range(0, 3)));
            end else begin
               reading = (last_reported != 0 && $urandom_range(0, 4) == 0)
                         ? int'(last_reported) : $urandom_range(1, 999);
               run_reading(reading, repeat_setting + $urandom_range(0, 2), 1'b1);
            end
         end
         phase++;
      end
   endtask

   task automatic test_steady_stream();
      set_config(3, 1);
      sender_idles = 1'b0;
      receiver_stalls = 1'b0;
      repeat (6) run_reading($urandom_range(1, 999), 2, 1'b0);
   endtask

   initial begin
      gap_setting = GAP_LENGTH_RST;
      repeat_setting = STABLE_REPEATS_RST;
      line_synced = 1'b0;
      last_clock = 1'b0;
      low_count = 0;
      held_bits = '0;
      held_count = 0;
      cand_temp = '0;
      cand_ok = 1'b0;
      same_count = 0;
      last_reported = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      sender_idles = 1'b1;
      receiver_stalls = 1'b1;

      test_default_settings();
      test_gap_extremes();
      test_segment_table();
      test_frame_faults();
      test_long_stability();
      test_random_traffic();
      test_steady_stream();

      settle();
      if (mismatch_count == 0)
         $display("segment_bus_temperature_sniffer_test passed");
      else
         $display("segment_bus_temperature_sniffer_test failed");
      $finish;
   end

   initial begin
      #40_000_000;
      $display("segment_bus_temperature_sniffer_test failed");
      $finish;
   end

endmodule
